/* rtl/core/dcc_pkg.sv */
// Shared types and constants for the differential correlation classifier.
`default_nettype none
package dcc_pkg;

    // Field and accumulator widths
    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 17;
    localparam int SX_W     = 27;
    localparam int SXX_W    = 41;
    localparam int SXY_W    = 42;
    localparam int CNT_W    = 11;
    localparam int CORR_W   = 16;
    localparam int CLASS_W  = 2;

    // Sample limit per condition (also bounded by the counter width)
    localparam logic [CNT_W-1:0] MAX_SAMPLES = 11'd1024;
    localparam logic [CNT_W-1:0] COUNT_MAX   = 11'd2047;
    localparam logic [THR_W-1:0] THR_RESET   = 17'd16384;

    // Intermediate widths
    localparam int VAR_W = 56;   // signed variance / covariance
    localparam int MA_W  = 106;  // multiplicand
    localparam int MB_W  = 54;   // multiplier
    localparam int MP_W  = 140;  // product

    // Change classes
    localparam logic [CLASS_W-1:0] CLASS_UNCHANGE = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_DOWN     = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_UP       = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_XX, S_YY, S_XY,
        S_NSXX, S_SXSX, S_NSYY, S_SYSY, S_NSXY, S_SXSY, S_CHK,
        S_P, S_C2, S_SRCH, S_OD2, S_LHS, S_NEXTC, S_OUT
    } state_t;

    typedef struct packed {
        logic            start;
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic            done;
        logic [MP_W-1:0] prod;
    } mul_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/dcc_mul.sv */
// Shift-and-add multiplier shared by all products of the classifier.
`default_nettype none
module dcc_mul (
    input  wire               clk,
    input  wire               rst_n,
    input  dcc_pkg::mul_req_t req,
    output dcc_pkg::mul_rsp_t rsp
);
    import dcc_pkg::*;

    logic [MP_W-1:0] a_reg;
    logic [MB_W-1:0] b_reg;
    logic [MP_W-1:0] acc_reg;
    logic            busy_reg;
    logic            done_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (b_reg[MB_W-1:1] == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Add one partial product per cycle, stop once the multiplier runs out
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= {{(MP_W-MA_W){1'b0}}, req.a};
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + a_reg;
            a_reg <= {a_reg[MP_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MB_W-1:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule
`default_nettype wire

/* rtl/core/differential_correlation_classifier.sv */
// Top level: per-condition accumulation and Pearson correlation change classifier.
// Usage:
//   s_* channel takes one paired sample per request: s_tdata = {sample_y, sample_x}
//   (sample_x lowest), s_tuser = condition, s_tlast = last sample of the pair.
//   m_* channel delivers one result per request carrying s_tlast.
//   cfg_we/cfg_wdata write change_threshold (Q1.15, reset 16384) while idle.
// Operation:
//   Each product runs on the shared shift-and-add unit, which steps through the
//   multiplier bits up to the highest set bit of the multiplier. A sample takes
//   three products of up to 16 multiplier bits, and s_tready stays low until they
//   are done (when its condition is already full, the sample is dropped in the load
//   state instead). On a last sample each condition then needs six set-up products,
//   two wide products and a binary search of up to 16 steps of two products each,
//   after which the result for both conditions is presented on m_*.
// Reset clears all sums and counts and restores the threshold.
// A result waits in its output register until m_tready; no new sample is
// taken until it has gone.
`default_nettype none
module differential_correlation_classifier (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // sample_x[15:0], sample_y[31:16]
    input  wire         s_tuser,   // condition
    input  wire         s_tlast,   // last
    output logic        m_tvalid,
    input  wire         m_tready,
    // corr_first[15:0], corr_second[31:16], first_valid[32], second_valid[33],
    // change_class[35:34], zero[39:36]
    output logic [39:0] m_tdata,
    input  wire         cfg_we,
    input  wire  [16:0] cfg_wdata
);
    import dcc_pkg::*;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;

    logic [THR_W-1:0]           thr_reg;
    logic signed [SAMPLE_W-1:0] x_reg, y_reg;
    logic                       last_reg;
    logic                       cc_reg;

    logic [SX_W-1:0]  sum_x_reg  [2];
    logic [SX_W-1:0]  sum_y_reg  [2];
    logic [SXX_W-1:0] sum_xx_reg [2];
    logic [SXX_W-1:0] sum_yy_reg [2];
    logic [SXY_W-1:0] sum_xy_reg [2];
    logic [CNT_W-1:0] count_reg  [2];

    logic signed [VAR_W-1:0] t1_reg, vx_reg, vy_reg, cv_reg;
    logic [MA_W-1:0]         p_reg;
    logic [MP_W-1:0]         rhs_reg;
    logic [15:0]             lo_reg, hi_reg, mid_reg;
    logic [31:0]             od2_reg;
    logic [CORR_W-1:0]       r_reg [2];
    logic                    v_reg [2];
    logic [CLASS_W-1:0]      class_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    dcc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // Magnitudes and signs of operands
    logic [SAMPLE_W-1:0] ax, ay;
    logic [SX_W-1:0]     asx, asy;
    logic [SXY_W-1:0]    asxy;
    logic [MB_W-1:0]     acv;
    logic [CNT_W-1:0]    n_cur;
    logic                is_mul, step_done, count_ok;
    logic [16:0]         mid_sum;
    logic [15:0]         mid_val;
    logic [16:0]         od_val;
    logic signed [VAR_W-1:0] prod_s;
    logic [CORR_W-1:0]   r_fin;
    logic signed [16:0]  diff;
    logic [16:0]         adiff;

    always_comb
    begin
        ax    = x_reg[SAMPLE_W-1] ? SAMPLE_W'(-x_reg) : x_reg;
        ay    = y_reg[SAMPLE_W-1] ? SAMPLE_W'(-y_reg) : y_reg;
        asx   = sum_x_reg[cc_reg][SX_W-1] ? (~sum_x_reg[cc_reg] + 1'b1) : sum_x_reg[cc_reg];
        asy   = sum_y_reg[cc_reg][SX_W-1] ? (~sum_y_reg[cc_reg] + 1'b1) : sum_y_reg[cc_reg];
        asxy  = sum_xy_reg[cc_reg][SXY_W-1] ? (~sum_xy_reg[cc_reg] + 1'b1)
                                             : sum_xy_reg[cc_reg];
        acv   = cv_reg[VAR_W-1] ? MB_W'(-cv_reg) : MB_W'(cv_reg);
        n_cur = count_reg[cc_reg];
        count_ok = (n_cur < MAX_SAMPLES) && (n_cur < COUNT_MAX);
        prod_s   = $signed({1'b0, mrsp.prod[VAR_W-2:0]});
        mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} + 17'd1;
        mid_val  = mid_sum[16:1];
        od_val   = {mid_val, 1'b0} - 17'd1;
        if (cv_reg[VAR_W-1])
            r_fin = CORR_W'(17'd0 - {1'b0, lo_reg});
        else
            r_fin = lo_reg[15] ? 16'h7FFF : lo_reg;
        diff  = $signed({r_reg[0][15], r_reg[0]}) - $signed({r_fin[15], r_fin});
        adiff = diff[16] ? 17'(-diff) : 17'(diff);
    end

    // Pick multiplier operands per state
    always_comb
    begin
        is_mul = 1'b1;
        mreq.a = '0;
        mreq.b = '0;
        unique case (state_reg)
            S_XX:   begin mreq.a = MA_W'(ax);  mreq.b = MB_W'(ax); end
            S_YY:   begin mreq.a = MA_W'(ay);  mreq.b = MB_W'(ay); end
            S_XY:   begin mreq.a = MA_W'(ax);  mreq.b = MB_W'(ay); end
            S_NSXX: begin mreq.a = MA_W'(sum_xx_reg[cc_reg]); mreq.b = MB_W'(n_cur); end
            S_SXSX: begin mreq.a = MA_W'(asx); mreq.b = MB_W'(asx); end
            S_NSYY: begin mreq.a = MA_W'(sum_yy_reg[cc_reg]); mreq.b = MB_W'(n_cur); end
            S_SYSY: begin mreq.a = MA_W'(asy); mreq.b = MB_W'(asy); end
            S_NSXY: begin mreq.a = MA_W'(asxy); mreq.b = MB_W'(n_cur); end
            S_SXSY: begin mreq.a = MA_W'(asx); mreq.b = MB_W'(asy); end
            S_P:    begin mreq.a = MA_W'(vx_reg[52:0]); mreq.b = MB_W'(vy_reg[53:0]); end
            S_C2:   begin mreq.a = MA_W'(acv); mreq.b = acv; end
            S_OD2:  begin mreq.a = MA_W'(mid_reg); mreq.b = MB_W'(mid_reg); end
            S_LHS:  begin mreq.a = p_reg; mreq.b = MB_W'(od2_reg); end
            default: is_mul = 1'b0;
        endcase
        mreq.start  = is_mul && !issued_reg;
        step_done   = is_mul && issued_reg && mrsp.done;
    end

    // Next state and handshake outputs
    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        if (is_mul && !issued_reg)
            issued_next = 1'b1;
        if (step_done)
            issued_next = 1'b0;
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_LOAD;
            S_LOAD:
            begin
                if (count_ok)
                    state_next = S_XX;
                else if (last_reg)
                    state_next = S_NSXX;
                else
                    state_next = S_IDLE;
            end
            S_XX:    if (step_done) state_next = S_YY;
            S_YY:    if (step_done) state_next = S_XY;
            S_XY:    if (step_done) state_next = last_reg ? S_NSXX : S_IDLE;
            S_NSXX:  if (step_done) state_next = S_SXSX;
            S_SXSX:  if (step_done) state_next = S_NSYY;
            S_NSYY:  if (step_done) state_next = S_SYSY;
            S_SYSY:  if (step_done) state_next = S_NSXY;
            S_NSXY:  if (step_done) state_next = S_SXSY;
            S_SXSY:  if (step_done) state_next = S_CHK;
            S_CHK:
            begin
                if (n_cur >= 11'd2 && vx_reg > 0 && vy_reg > 0)
                    state_next = S_P;
                else
                    state_next = S_NEXTC;
            end
            S_P:     if (step_done) state_next = S_C2;
            S_C2:    if (step_done) state_next = S_SRCH;
            S_SRCH:  state_next = (lo_reg == hi_reg) ? S_NEXTC : S_OD2;
            S_OD2:   if (step_done) state_next = S_LHS;
            S_LHS:   if (step_done) state_next = S_SRCH;
            S_NEXTC: state_next = cc_reg ? S_OUT : S_NSXX;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            thr_reg    <= THR_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            if (cfg_we)
                thr_reg <= cfg_wdata;
        end
    end

    // Accumulators and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sum_x_reg[i]  <= '0;
                sum_y_reg[i]  <= '0;
                sum_xx_reg[i] <= '0;
                sum_yy_reg[i] <= '0;
                sum_xy_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end
        else if (state_reg == S_NEXTC && cc_reg)
        begin
            for (int i = 0; i < 2; i++)
            begin
                sum_x_reg[i]  <= '0;
                sum_y_reg[i]  <= '0;
                sum_xx_reg[i] <= '0;
                sum_yy_reg[i] <= '0;
                sum_xy_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end
        else if (step_done)
        begin
            unique case (state_reg)
                S_XX: sum_xx_reg[cc_reg] <= sum_xx_reg[cc_reg] + SXX_W'(mrsp.prod[31:0]);
                S_YY: sum_yy_reg[cc_reg] <= sum_yy_reg[cc_reg] + SXX_W'(mrsp.prod[31:0]);
                S_XY:
                begin
                    if (x_reg[SAMPLE_W-1] ^ y_reg[SAMPLE_W-1])
                        sum_xy_reg[cc_reg] <= sum_xy_reg[cc_reg] - SXY_W'(mrsp.prod[31:0]);
                    else
                        sum_xy_reg[cc_reg] <= sum_xy_reg[cc_reg] + SXY_W'(mrsp.prod[31:0]);
                    sum_x_reg[cc_reg] <= sum_x_reg[cc_reg] + SX_W'(x_reg);
                    sum_y_reg[cc_reg] <= sum_y_reg[cc_reg] + SX_W'(y_reg);
                    count_reg[cc_reg] <= count_reg[cc_reg] + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Control-side payload: selected condition
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cc_reg <= 1'b0;
        else if (state_reg == S_IDLE && s_tvalid)
            cc_reg <= s_tuser;
        else if ((state_reg == S_LOAD && !count_ok && last_reg)
                 || (state_reg == S_XY && step_done && last_reg))
            cc_reg <= 1'b0;
        else if (state_reg == S_NEXTC)
            cc_reg <= ~cc_reg;
    end

    // Correlation datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            x_reg    <= $signed(s_tdata[15:0]);
            y_reg    <= $signed(s_tdata[31:16]);
            last_reg <= s_tlast;
        end
        if (step_done)
        begin
            unique case (state_reg)
                S_NSXX, S_NSYY: t1_reg <= prod_s;
                S_SXSX: vx_reg <= t1_reg - prod_s;
                S_SYSY: vy_reg <= t1_reg - prod_s;
                S_NSXY: t1_reg <= sum_xy_reg[cc_reg][SXY_W-1] ? -prod_s : prod_s;
                S_SXSY: cv_reg <= (sum_x_reg[cc_reg][SX_W-1] ^ sum_y_reg[cc_reg][SX_W-1])
                                  ? t1_reg + prod_s : t1_reg - prod_s;
                S_P:    p_reg <= mrsp.prod[MA_W-1:0];
                S_C2:
                begin
                    rhs_reg <= {mrsp.prod[MP_W-33:0], 32'd0};
                    lo_reg  <= 16'd0;
                    hi_reg  <= 16'd32768;
                end
                S_OD2:  od2_reg <= mrsp.prod[31:0];
                S_LHS:
                begin
                    if (mrsp.prod <= rhs_reg)
                        lo_reg <= mid_reg;
                    else
                        hi_reg <= mid_reg - 16'd1;
                end
                default: ;
            endcase
        end
        if (state_reg == S_SRCH)
        begin
            mid_reg <= od_val[15:0];
            if (lo_reg == hi_reg)
            begin
                r_reg[cc_reg] <= r_fin;
                v_reg[cc_reg] <= 1'b1;
            end
        end
        // Mid is kept as the odd factor 2m-1; recover m for the search update
        if (state_reg == S_OD2 && step_done)
            mid_reg <= mid_val;
        if (state_reg == S_CHK
            && !(n_cur >= 11'd2 && vx_reg > 0 && vy_reg > 0))
        begin
            r_reg[cc_reg] <= '0;
            v_reg[cc_reg] <= 1'b0;
        end
        if (state_reg == S_NEXTC && cc_reg)
        begin
            if (v_reg[0] && v_reg[1] && adiff >= thr_reg)
                class_reg <= ($signed(r_reg[0]) >= $signed(r_reg[1])) ? CLASS_DOWN
                                                                      : CLASS_UP;
            else
                class_reg <= CLASS_UNCHANGE;
        end
    end

    assign m_tdata = {4'd0, class_reg, v_reg[1], v_reg[0], r_reg[1], r_reg[0]};

endmodule
`default_nettype wire

/* sim/differential_correlation_classifier_tb.sv */
// Self-checking testbench for the differential correlation classifier.
`timescale 1ns / 100ps
`default_nettype none
module differential_correlation_classifier_tb;
    import dcc_pkg::*;

    localparam int IDLE_LIMIT   = 40000;
    localparam int SETTLE_TICKS = 300;

    // Packed from the highest bits down, so corr_first lands in the lowest bits
    typedef struct packed {
        logic [1:0]         change_class;
        logic               second_valid;
        logic               first_valid;
        logic signed [15:0] corr_second;
        logic signed [15:0] corr_first;
    } corr_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [16:0] cfg_wdata;

    // Predictor state: per-condition sums and counts, plus the threshold
    logic [SX_W-1:0]  acc_x  [2];
    logic [SX_W-1:0]  acc_y  [2];
    logic [SXX_W-1:0] acc_xx [2];
    logic [SXX_W-1:0] acc_yy [2];
    logic [SXY_W-1:0] acc_xy [2];
    int               acc_n  [2];
    logic [THR_W-1:0] threshold;

    corr_result_t pending_results[$];
    int  fail_count;
    int  samples_sent;
    int  results_seen;
    int  burst_left;
    int  idle_cycles;
    int  rx_mode;
    int  rx_tick;

    differential_correlation_classifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Exact Q1.15 correlation of one condition
    function automatic int pearson_q15(input int c, output logic defined);
        longint      n;
        longint      sx;
        longint      sy;
        longint      sxx;
        longint      syy;
        longint      sxy;
        longint      vx;
        longint      vy;
        longint      cv;
        longint      ac;
        logic [159:0] wa;
        logic [159:0] wb;
        logic [159:0] vprod;
        logic [159:0] rhs;
        logic [159:0] lhs;
        logic [159:0] od;
        int          lo;
        int          hi;
        int          mid;
        n   = acc_n[c];
        sx  = longint'($signed(acc_x[c]));
        sy  = longint'($signed(acc_y[c]));
        sxx = longint'({23'b0, acc_xx[c]});
        syy = longint'({23'b0, acc_yy[c]});
        sxy = longint'($signed(acc_xy[c]));
        vx  = n * sxx - sx * sx;
        vy  = n * syy - sy * sy;
        cv  = n * sxy - sx * sy;
        defined = 1'b0;
        if (n < 2 || vx <= 0 || vy <= 0)
            return 0;
        defined = 1'b1;
        ac = (cv < 0) ? -cv : cv;
        wa = 160'(vx);
        wb = 160'(vy);
        vprod = wa * wb;
        wa = 160'(ac);
        rhs = (wa * wa) << 32;
        // Largest m with (2m-1)^2 * Vx*Vy <= 2^32 * C^2
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            od  = 160'(2 * mid - 1);
            lhs = od * od * vprod;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (cv < 0)
            return -lo;
        return (lo > 32767) ? 32767 : lo;
    endfunction

    // Accumulate one accepted request; on last, queue the expected result and clear
    task automatic predict_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                                  input logic c, input logic lst);
        longint       px;
        longint       py;
        longint       pxy;
        int           r1;
        int           r2;
        int           diff;
        logic         v1;
        logic         v2;
        corr_result_t res;
        px  = longint'(x) * longint'(x);
        py  = longint'(y) * longint'(y);
        pxy = longint'(x) * longint'(y);
        if (acc_n[c] < int'(MAX_SAMPLES) && acc_n[c] < int'(COUNT_MAX))
        begin
            acc_x[c]  = acc_x[c] + {{(SX_W-16){x[15]}}, x};
            acc_y[c]  = acc_y[c] + {{(SX_W-16){y[15]}}, y};
            acc_xx[c] = acc_xx[c] + px[SXX_W-1:0];
            acc_yy[c] = acc_yy[c] + py[SXX_W-1:0];
            acc_xy[c] = acc_xy[c] + pxy[SXY_W-1:0];
            acc_n[c]++;
        end
        if (!lst)
            return;
        r1 = pearson_q15(0, v1);
        r2 = pearson_q15(1, v2);
        res.corr_first   = 16'(r1);
        res.corr_second  = 16'(r2);
        res.first_valid  = v1;
        res.second_valid = v2;
        res.change_class = CLASS_UNCHANGE;
        if (v1 && v2)
        begin
            diff = (r1 > r2) ? r1 - r2 : r2 - r1;
            if (diff >= int'(threshold))
                res.change_class = (r1 >= r2) ? CLASS_DOWN : CLASS_UP;
        end
        pending_results = {pending_results, res};
        for (int i = 0; i < 2; i++)
        begin
            acc_x[i] = '0; acc_y[i] = '0; acc_xx[i] = '0;
            acc_yy[i] = '0; acc_xy[i] = '0; acc_n[i] = 0;
        end
    endtask

    // Send one sample request, with bursts and random gaps ahead of it
    task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic c, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                @(posedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
        end
        burst_left--;
        @(posedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= c;
        s_tlast  <= lst;
        do @(negedge clk); while (!s_tready);
        predict_sample(x, y, c, lst);
        samples_sent++;
    endtask

    // Lower valid, then wait for every expected result and let the block settle
    task automatic drain_results();
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        drain_results();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        threshold = value;
    endtask

    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    // Hand-picked pairs: extremes, undefined cases and each change class
    task automatic test_directed();
        send_sample(16'sd0, 16'sd0, 1'b0, 1'b1);
        send_sample(-16'sd32768, -16'sd32768, 1'b0, 1'b0);
        send_sample(16'sd32767, 16'sd32767, 1'b0, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_sample(-16'sd32768, 16'sd32767, 1'b1, 1'b0);
        send_sample(16'sd32767, -16'sd32768, 1'b1, 1'b0);
        send_sample(16'sd100, -16'sd100, 1'b1, 1'b1);
        send_sample(16'sd3, -16'sd3, 1'b0, 1'b0);
        send_sample(-16'sd7, 16'sd9, 1'b0, 1'b0);
        send_sample(16'sd1, 16'sd2, 1'b1, 1'b0);
        send_sample(16'sd5, 16'sd11, 1'b1, 1'b1);
        send_sample(16'sd5, 16'sd1, 1'b0, 1'b0);
        send_sample(16'sd5, 16'sd2, 1'b0, 1'b0);
        send_sample(16'sd1, 16'sd1, 1'b1, 1'b0);
        send_sample(16'sd2, 16'sd3, 1'b1, 1'b1);
        send_sample(16'sd1, 16'sd2, 1'b0, 1'b0);
        send_sample(16'sd2, 16'sd5, 1'b0, 1'b0);
        send_sample(16'sd4, 16'sd6, 1'b0, 1'b0);
        send_sample(16'sd1, 16'sd2, 1'b1, 1'b0);
        send_sample(16'sd2, 16'sd4, 1'b1, 1'b0);
        send_sample(16'sd4, 16'sd7, 1'b1, 1'b1);
        send_sample(16'sd9, 16'sd9, 1'b1, 1'b1);
    endtask

    // One random pair: mostly correlated data, sometimes pure noise
    task automatic send_random_pair(input int len);
        int   slope;
        int   spread;
        int   xv;
        logic c;
        slope  = $urandom_range(0, 4) - 2;
        spread = 1 << $urandom_range(0, 15);
        for (int i = 0; i < len; i++)
        begin
            c  = 1'($urandom_range(0, 1));
            xv = $signed(16'($urandom));
            if ($urandom_range(0, 5) == 0)
                send_sample(16'($urandom), 16'($urandom), c, i == len - 1);
            else
                send_sample(clip16(xv), clip16((c ? -slope : slope) * xv / 2
                            + int'($urandom_range(0, 2 * spread)) - spread), c, i == len - 1);
        end
    endtask

    task automatic test_random(input int budget);
        int used;
        int len;
        used = 0;
        while (used < budget)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            send_random_pair(len);
            used += len;
            if (used > budget / 2 && used - len <= budget / 2)
                drain_results();
        end
    endtask

    // Run one condition past its sample limit, ending on an ignored sample
    task automatic test_sample_limit();
        for (int i = 0; i < int'(MAX_SAMPLES) + 6; i++)
            send_sample(16'($urandom), 16'(i * 37), 1'b0, 1'b0);
        send_sample(16'sd11, 16'sd12, 1'b1, 1'b0);
        send_sample(16'sd13, 16'sd2, 1'b1, 1'b0);
        send_sample(16'sd1234, 16'sd4321, 1'b0, 1'b1);
    endtask

    task automatic test_thresholds();
        write_threshold(17'd0);
        test_random(200);
        write_threshold(17'd65536);
        test_random(150);
        write_threshold(17'($urandom_range(1, 65535)));
        test_random(150);
        write_threshold(17'($urandom_range(64, 2048)));
        test_random(100);
    endtask

    // Receiver stall pattern: runs of always-ready, random and mostly stalled
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 300 == 0)
            rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (rx_tick % 9 == 0);
        endcase
    end

    // Check each result just ahead of the edge that takes it
    always @(negedge clk)
    begin
        corr_result_t got;
        corr_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[35:0];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.corr_first !== want.corr_first)
                begin
                    $error("corr_first expected %0d got %0d", want.corr_first, got.corr_first);
                    fail_count++;
                end
                if (got.corr_second !== want.corr_second)
                begin
                    $error("corr_second expected %0d got %0d", want.corr_second,
                           got.corr_second);
                    fail_count++;
                end
                if (got.first_valid !== want.first_valid)
                begin
                    $error("first_valid expected %0b got %0b", want.first_valid,
                           got.first_valid);
                    fail_count++;
                end
                if (got.second_valid !== want.second_valid)
                begin
                    $error("second_valid expected %0b got %0b", want.second_valid,
                           got.second_valid);
                    fail_count++;
                end
                if (got.change_class !== want.change_class)
                begin
                    $error("change_class expected %0d got %0d", want.change_class,
                           got.change_class);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run after too long with no request moving
    always @(negedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rx_mode = 0;
        rx_tick = 1;
        idle_cycles = 0;
        fail_count = 0;
        samples_sent = 0;
        results_seen = 0;
        burst_left = 0;
        threshold = THR_RESET;
        for (int i = 0; i < 2; i++)
        begin
            acc_x[i] = '0; acc_y[i] = '0; acc_xx[i] = '0;
            acc_yy[i] = '0; acc_xy[i] = '0; acc_n[i] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(100);
        test_sample_limit();
        test_thresholds();
        drain_results();

        $display("Sent %0d samples and checked %0d correlation results", samples_sent,
                 results_seen);
        $display("covering undefined pairs, the sample limit and four thresholds");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
